[rtl/fpa_pkg.sv]
// Package for the Fenwick point-add / range-sum unit: field widths, codes,
// the controller state type and the command and status structs.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  localparam int unsigned SizeDef  = 1024;
  localparam int unsigned CellW    = 48;
  localparam int unsigned DeltaW   = 32;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  localparam logic [CfgW-1:0] SizeReset = 11'd1024;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_HI_RD,
    ST_HI_ACC,
    ST_LO_RD,
    ST_LO_ACC,
    ST_RESULT
  } fpa_state_e;

  typedef struct packed {
    logic clr_wr;
    logic load_add;
    logic load_query;
    logic rd;
    logic add_wr;
    logic acc_add;
    logic acc_sub;
    logic step_down;
    logic start_lo;
    logic out_load;
  } fpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_kind;
    logic add_in_range;
    logic cnt_zero;
    logic cnt_past;
    logic out_free;
  } fpa_status_t;

endpackage

`default_nettype wire

[rtl/fpa_ctrl.sv]
// Controller of the Fenwick unit: the state machine that sequences clearing,
// point adds and the two prefix walks of a range query.
// Depends on fpa_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fpa_ctrl
  import fpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  fpa_status_t stat_i,
  output logic        in_ready_o,
  output fpa_cmd_t    cmd_o
);

  fpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_e'(stat_i.in_kind) == KIND_QUERY) begin
            state_d = ST_HI_RD;
          end else if (stat_i.add_in_range) begin
            state_d = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        state_d = stat_i.cnt_past ? ST_IDLE : ST_ADD_WR;
      end
      ST_ADD_WR: state_d = ST_ADD_RD;
      ST_HI_RD: begin
        state_d = stat_i.cnt_zero ? ST_LO_RD : ST_HI_ACC;
      end
      ST_HI_ACC: state_d = ST_HI_RD;
      ST_LO_RD: begin
        state_d = stat_i.cnt_zero ? ST_RESULT : ST_LO_ACC;
      end
      ST_LO_ACC: state_d = ST_LO_RD;
      ST_RESULT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_e'(stat_i.in_kind) == KIND_QUERY) begin
            cmd_o.load_query = 1'b1;
          end else if (stat_i.add_in_range) begin
            cmd_o.load_add = 1'b1;
          end
        end
      end
      ST_ADD_RD: cmd_o.rd = !stat_i.cnt_past;
      ST_ADD_WR: cmd_o.add_wr = 1'b1;
      ST_HI_RD: begin
        cmd_o.rd       = !stat_i.cnt_zero;
        cmd_o.start_lo = stat_i.cnt_zero;
      end
      ST_HI_ACC: begin
        cmd_o.acc_add   = 1'b1;
        cmd_o.step_down = 1'b1;
      end
      ST_LO_RD: cmd_o.rd = !stat_i.cnt_zero;
      ST_LO_ACC: begin
        cmd_o.acc_sub   = 1'b1;
        cmd_o.step_down = 1'b1;
      end
      ST_RESULT: cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/fpa_datapath.sv]
// Datapath of the Fenwick unit: the cell memory, the index walker, the
// accumulator, the size register and the output register.
// Depends on fpa_pkg; driven by fpa_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module fpa_datapath
  import fpa_pkg::*;
#(
  parameter int unsigned SIZE = SizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpa_cmd_t            cmd_i,
  output fpa_status_t         stat_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_kind_i,
  input  logic                cfg_valid_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_flag_o
);

  localparam int unsigned AddrW = (SIZE > 1) ? $clog2(SIZE) : 1;
  // Wide enough for the size register and for an index that has stepped
  // past the active size on an upward walk.
  localparam int unsigned CntW  = (AddrW + 1 > CfgW + 1) ? AddrW + 1 : CfgW + 1;

  logic [CfgW-1:0]   size_q;
  logic [CntW-1:0]   size_ext, n_act;
  logic [IdxW-1:0]   first_in, last_in;
  logic [DeltaW-1:0] delta_in;
  logic [CntW-1:0]   first_ext, last_ext, first_c, last_c;
  logic              first_over, last_over;

  logic [CntW-1:0]   cnt_q, lo_cnt_q, low_bit, cnt_m1;
  logic [AddrW-1:0]  cell_addr, clr_q;
  logic [CellW-1:0]  delta_q, acc_q, rd_q;
  logic              flag_q;
  logic [CellW-1:0]  cell_mem [SIZE];

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // A size of zero acts as one, a size beyond the built depth as the depth.
  assign size_ext = CntW'(size_q);
  always_comb begin
    if (size_ext == '0) begin
      n_act = CntW'(1);
    end else if (size_ext > CntW'(SIZE)) begin
      n_act = CntW'(SIZE);
    end else begin
      n_act = size_ext;
    end
  end

  assign first_in   = in_data_i[IdxW-1:0];
  assign last_in    = in_data_i[2*IdxW-1:IdxW];
  assign delta_in   = in_data_i[2*IdxW+DeltaW-1:2*IdxW];
  assign first_ext  = CntW'(first_in);
  assign last_ext   = CntW'(last_in);
  assign first_over = first_ext >= n_act;
  assign last_over  = last_ext >= n_act;
  assign first_c    = first_over ? n_act - CntW'(1) : first_ext;
  assign last_c     = last_over ? n_act - CntW'(1) : last_ext;

  assign low_bit   = cnt_q & (~cnt_q + CntW'(1));
  assign cnt_m1    = cnt_q - CntW'(1);
  assign cell_addr = cnt_m1[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_add) begin
      cnt_q   <= first_ext + CntW'(1);
      delta_q <= {{(CellW-DeltaW){delta_in[DeltaW-1]}}, delta_in};
    end
    if (cmd_i.load_query) begin
      cnt_q    <= last_c + CntW'(1);
      lo_cnt_q <= first_c;
      flag_q   <= first_over | last_over;
      acc_q    <= '0;
    end
    if (cmd_i.start_lo)  cnt_q <= lo_cnt_q;
    if (cmd_i.step_down) cnt_q <= cnt_q - low_bit;
    if (cmd_i.add_wr)    cnt_q <= cnt_q + low_bit;
    // The upper prefix is added and the lower one taken off in the same register.
    if (cmd_i.acc_add)   acc_q <= acc_q + rd_q;
    if (cmd_i.acc_sub)   acc_q <= acc_q - rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      cell_mem[clr_q] <= '0;
    end else if (cmd_i.add_wr) begin
      cell_mem[cell_addr] <= rd_q + delta_q;
    end
    if (cmd_i.rd) begin
      rd_q <= cell_mem[cell_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= acc_q;
      out_flag_q <= flag_q;
    end
  end

  assign stat_o.clr_last     = clr_q == AddrW'(SIZE - 1);
  assign stat_o.in_kind      = in_kind_i;
  assign stat_o.add_in_range = !first_over;
  assign stat_o.cnt_zero     = cnt_q == '0;
  assign stat_o.cnt_past     = cnt_q > n_act;
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flag_o  = out_flag_q;

endmodule

`default_nettype wire

[rtl/fenwick_point_add_range_sum_unit.sv]
// Top level of the Fenwick point-add / range-sum unit: stream ports, the
// configuration port, and the controller and datapath joined together.
// Depends on fpa_pkg, fpa_ctrl and fpa_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The unit keeps SIZE cells of 48 bits in one single-port memory and handles
// one word at a time. After reset it clears the memory, one cell a cycle, until
// all SIZE cells are zero, and accepts no input word until that is done;
// configuration writes are taken throughout. A point add walks the cells on its
// upward chain; a query walks the chain down from last+1 and then from first.
// Each chain step is one registered memory read followed by an accumulate or a
// write back. A finished sum waits in the output register while the next word
// is taken.
module fenwick_point_add_range_sum_unit
  import fpa_pkg::*;
#(
  parameter int unsigned SIZE = SizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // first_index [9:0], last_index [19:10], delta [51:20], zero [55:52]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind [0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // range_total [47:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  // index_clamped [0]
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i
);

  fpa_cmd_t    cmd;
  fpa_status_t stat;

  assign cfg_ready_o = 1'b1;

  fpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  fpa_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_flag_o  (m_axis_tuser)
  );

  // No input word is taken while the memory is being cleared.
  a_no_accept_in_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.clr_wr |-> !s_axis_tready)
    else $error("input accepted during memory clear");

  // A new sum never overwrites one that has not been taken.
  a_no_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && m_axis_tvalid) |-> m_axis_tready)
    else $error("result register overwritten");

  // An accepted query keeps the unit busy in the following cycle.
  a_query_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("query accepted without walking the tree");

  // Clearing writes and chain reads never share the memory port.
  a_port_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.clr_wr |-> !(cmd.rd || cmd.add_wr))
    else $error("memory port conflict");

endmodule

`default_nettype wire

[bench/fenwick_point_add_range_sum_unit_tb.sv]
// Self-checking bench for the Fenwick point-add / range-sum unit: a directed
// table then random phases over several sizes, checked against a local model.
// Depends on fpa_pkg and fenwick_point_add_range_sum_unit.
`timescale 1ns / 1ps
`default_nettype none

module fenwick_point_add_range_sum_unit_tb
  import fpa_pkg::*;
;

  localparam int unsigned QuietLimit  = 4000;  // cycles with no word moving
  localparam int unsigned SettleCyc   = 64;    // longest add or query, with margin
  localparam int unsigned PhaseWords  = 50;
  localparam int unsigned PhaseCount  = 9;

  typedef enum logic [1:0] {
    ROW_ADD,
    ROW_QUERY,
    ROW_SIZE
  } row_e;

  typedef struct {
    row_e            op;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
    logic [31:0]     value;   // delta, or the size for a ROW_SIZE row
    bit              typed;
    logic [CellW-1:0] total;
    logic            clamped;
  } row_t;

  typedef struct {
    logic [CellW-1:0] total;
    logic             clamped;
  } sum_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;

  fenwick_point_add_range_sum_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Local copy of the tree and of the size register.
  logic [CellW-1:0] fw_cells [0:SizeDef-1];
  logic [CfgW-1:0]  size_reg;

  sum_t pending_sums [$];
  row_t script [$];
  int   mismatches;
  int   quiet_cycles;
  bit   calm;
  sum_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_size();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > SizeDef) n = SizeDef;
    return n;
  endfunction

  function automatic logic [CellW-1:0] prefix_total(input int count);
    logic [CellW-1:0] acc;
    int i;
    acc = '0;
    i = count;
    while (i > 0) begin
      acc = acc + fw_cells[i-1];
      i = i - (i & -i);
    end
    return acc;
  endfunction

  function automatic void apply_add(input int pos, input logic [DeltaW-1:0] delta);
    logic [CellW-1:0] ext;
    int n;
    int i;
    ext = {{(CellW-DeltaW){delta[DeltaW-1]}}, delta};
    n = eff_size();
    // A position at or past the size in force leaves the tree alone.
    if (pos < n) begin
      i = pos + 1;
      while (i <= n) begin
        fw_cells[i-1] = fw_cells[i-1] + ext;
        i = i + (i & -i);
      end
    end
  endfunction

  function automatic sum_t range_query(input int first, input int last);
    sum_t r;
    int n;
    n = eff_size();
    r.clamped = 1'b0;
    if (first >= n) begin
      first = n - 1;
      r.clamped = 1'b1;
    end
    if (last >= n) begin
      last = n - 1;
      r.clamped = 1'b1;
    end
    r.total = prefix_total(last + 1) - prefix_total(first);
    return r;
  endfunction

  function automatic int pick_index(input int n);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, SizeDef - 1);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic put_row(input row_e op, input int first, input int last,
                         input logic [31:0] value, input bit typed,
                         input logic [CellW-1:0] total, input logic clamped);
    row_t r;
    r.op = op;
    r.first = IdxW'(first);
    r.last = IdxW'(last);
    r.value = value;
    r.typed = typed;
    r.total = total;
    r.clamped = clamped;
    script.insert(script.size(), r);
  endtask

  // Offers one word, with random gaps first, and updates the model once the
  // word has been taken.
  task automatic issue_word(input kind_e kind, input logic [IdxW-1:0] first,
                            input logic [IdxW-1:0] last, input logic [DeltaW-1:0] delta,
                            input bit typed, input sum_t typed_sum);
    sum_t r;
    while (!calm && $urandom_range(0, 99) < 34) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {4'b0, delta, last, first};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_ADD) begin
      apply_add(first, delta);
    end else begin
      r = range_query(first, last);
      if (typed) r = typed_sum;
      pending_sums.insert(pending_sums.size(), r);
    end
  endtask

  task automatic wait_for_sums();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // An add gives no result, so the unit may still be walking a chain when
  // the last sum has arrived.
  task automatic write_size(input logic [CfgW-1:0] value);
    wait_for_sums();
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    size_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum word: total %h clamped %b", $time,
                 m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata !== want.total) begin
          $display("%0t: range_total expected %h actual %h", $time, want.total,
                   m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.clamped) begin
          $display("%0t: index_clamped expected %b actual %b", $time, want.clamped,
                   m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [CfgW-1:0] phase_size [0:PhaseCount-1];
    sum_t            typed_sum;
    int              n;
    kind_e           kind;
    logic [DeltaW-1:0] delta;
    row_t            r;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ADD;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    size_reg      = SizeReset;
    for (int i = 0; i < SizeDef; i++) fw_cells[i] = '0;

    // Directed part: fresh tree, extreme deltas, reversed and clamped ranges,
    // adds past the size, and sizes below and above the legal range.
    put_row(ROW_QUERY, 0, 1023, 0, 1, 48'h0, 1'b0);
    put_row(ROW_QUERY, 1023, 0, 0, 1, 48'h0, 1'b0);
    put_row(ROW_ADD, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    put_row(ROW_ADD, 1023, 0, 32'h8000_0000, 0, 0, 0);
    put_row(ROW_QUERY, 0, 0, 0, 1, 48'h0000_7FFF_FFFF, 1'b0);
    put_row(ROW_QUERY, 1023, 1023, 0, 1, 48'hFFFF_8000_0000, 1'b0);
    put_row(ROW_QUERY, 0, 1023, 0, 1, 48'hFFFF_FFFF_FFFF, 1'b0);
    put_row(ROW_ADD, 512, 0, 32'hFFFF_FFFF, 0, 0, 0);
    put_row(ROW_ADD, 511, 0, 32'd5, 0, 0, 0);
    put_row(ROW_QUERY, 511, 512, 0, 0, 0, 0);
    put_row(ROW_QUERY, 600, 100, 0, 0, 0, 0);
    put_row(ROW_ADD, 0, 1023, 32'd0, 0, 0, 0);
    put_row(ROW_QUERY, 0, 1023, 0, 0, 0, 0);
    put_row(ROW_SIZE, 0, 0, 32'd16, 0, 0, 0);
    put_row(ROW_ADD, 16, 0, 32'd1000, 0, 0, 0);
    put_row(ROW_ADD, 1023, 0, 32'd7, 0, 0, 0);
    put_row(ROW_QUERY, 0, 20, 0, 0, 0, 0);
    put_row(ROW_QUERY, 20, 3, 0, 0, 0, 0);
    put_row(ROW_SIZE, 0, 0, 32'd0, 0, 0, 0);
    put_row(ROW_QUERY, 5, 9, 0, 0, 0, 0);
    put_row(ROW_ADD, 0, 0, 32'd3, 0, 0, 0);
    put_row(ROW_QUERY, 0, 0, 0, 0, 0, 0);
    put_row(ROW_SIZE, 0, 0, 32'd2047, 0, 0, 0);
    put_row(ROW_QUERY, 0, 1023, 0, 0, 0, 0);
    put_row(ROW_QUERY, 1000, 1023, 0, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      r = script[i];
      typed_sum.total   = r.total;
      typed_sum.clamped = r.clamped;
      case (r.op)
        ROW_SIZE: begin
          write_size(r.value[CfgW-1:0]);
        end
        ROW_ADD: begin
          issue_word(KIND_ADD, r.first, r.last, r.value, 1'b0, typed_sum);
        end
        default: begin
          issue_word(KIND_QUERY, r.first, r.last, r.value, r.typed, typed_sum);
        end
      endcase
    end

    phase_size[0] = 11'd1;
    phase_size[1] = 11'd8;
    phase_size[2] = 11'd1024;
    phase_size[3] = 11'd37;
    phase_size[4] = 11'd2;
    phase_size[5] = 11'd1000;
    phase_size[6] = 11'd0;
    phase_size[7] = 11'd2047;
    phase_size[8] = CfgW'($urandom_range(1, SizeDef));

    for (int p = 0; p < PhaseCount; p++) begin
      write_size(phase_size[p]);
      // One phase runs with both sides always ready.
      calm = (p == 2);
      n = eff_size();
      for (int w = 0; w < PhaseWords; w++) begin
        if ((p == 0 && w == 25) || $urandom_range(0, 99) < 2) wait_for_sums();
        kind = $urandom_range(0, 1) ? KIND_QUERY : KIND_ADD;
        case ($urandom_range(0, 15))
          0:       delta = 32'h7FFF_FFFF;
          1:       delta = 32'h8000_0000;
          2:       delta = 32'hFFFF_FFFF;
          3:       delta = 32'h0;
          default: delta = $urandom;
        endcase
        issue_word(kind, IdxW'(pick_index(n)), IdxW'(pick_index(n)), delta, 1'b0,
                   typed_sum);
      end
    end
    calm = 1'b0;

    wait_for_sums();
    repeat (SettleCyc) @(posedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

[fenwick_point_add_range_sum_unit.f]
rtl/fpa_pkg.sv
rtl/fpa_ctrl.sv
rtl/fpa_datapath.sv
rtl/fenwick_point_add_range_sum_unit.sv
bench/fenwick_point_add_range_sum_unit_tb.sv
